// ===== rtl/hccb_pkg.sv =====
// ---------------------------------------------------------------------------
// hccb_pkg: shared types and constants
// Widths, command and status codes, controller states and the node word
// that moves through the priority queue cells.
// ---------------------------------------------------------------------------
package hccb_pkg;

   localparam int ALPHA      = 512;
   localparam int SYM_W      = 9;
   localparam int NODE_W     = 10;
   localparam int NODE_COUNT = 2 * ALPHA - 1;
   localparam int FREQ_BITS  = 32;
   localparam int WEIGHT_W   = FREQ_BITS + SYM_W;
   localparam int LEN_W      = 6;
   localparam int MAX_LEN    = 63;
   localparam int LVL_CNT    = 64;
   localparam int CODE_W     = 64;
   localparam int CNT_W      = 10;
   localparam int CMD_W      = 2;
   localparam int STS_W      = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE     = 2'd0,
      CMD_BUILD     = 2'd1,
      CMD_READ_SYM  = 2'd2,
      CMD_READ_RANK = 2'd3
   } cmd_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 2'd0,
      STS_EMPTY     = 2'd1,
      STS_NOT_BUILT = 2'd2,
      STS_RANK      = 2'd3
   } sts_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RR1,
      ST_RS1,
      ST_FINISH,
      ST_LOAD0,
      ST_LOAD1,
      ST_MERGE_A,
      ST_MERGE_B,
      ST_MERGE_C,
      ST_DINIT,
      ST_N0,
      ST_N1,
      ST_N2,
      ST_N3,
      ST_P0,
      ST_P1,
      ST_A0,
      ST_A1,
      ST_A2
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [WEIGHT_W-1:0] weight;
      logic [SYM_W-1:0]    min_sym;
      logic [NODE_W-1:0]   id;
   } node_type;

   typedef struct packed {
      logic insert;
      logic extract;
   } qctl_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [CNT_W-1:0]  off;
   } ncode_type;

   // empty entries order after every live one
   function automatic logic node_less(node_type x, node_type y);
      logic r;
      if (!x.valid) begin
         r = 1'b0;
      end else if (!y.valid) begin
         r = 1'b1;
      end else if (x.weight != y.weight) begin
         r = (x.weight < y.weight);
      end else begin
         r = (x.min_sym < y.min_sym);
      end
      return r;
   endfunction

endpackage

// ===== rtl/hccb_if.sv =====
// ---------------------------------------------------------------------------
// hccb_req_if / hccb_rsp_if: request and response channels
// Valid/ready channels carrying one command word and one result word.
// ---------------------------------------------------------------------------
interface hccb_req_if import hccb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [SYM_W-1:0]     symbol_index;
   logic [FREQ_BITS-1:0] frequency;

   modport source(output valid, command, symbol_index, frequency, input ready);
   modport sink(input valid, command, symbol_index, frequency, output ready);
endinterface

interface hccb_rsp_if import hccb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STS_W-1:0]  status;
   logic [CNT_W-1:0]  coded_count;
   logic [SYM_W-1:0]  out_symbol;
   logic [LEN_W-1:0]  code_length;
   logic [CODE_W-1:0] code_bits;

   modport source(output valid, status, coded_count, out_symbol, code_length, code_bits,
                  input ready);
   modport sink(input valid, status, coded_count, out_symbol, code_length, code_bits,
                output ready);
endinterface

// ===== rtl/hccb_cell.sv =====
// ---------------------------------------------------------------------------
// hccb_cell: one slot of the sorted node queue
// Holds one node; on insert it keeps, takes the new node or takes its left
// neighbor; on extract it takes its right neighbor.
// ---------------------------------------------------------------------------
module hccb_cell import hccb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qctl_type ctl,
   input  node_type ins_node,
   input  node_type left_node,
   input  node_type right_node,
   input  logic     lt_left,
   output logic     lt_out,
   output node_type node_out
);

   node_type node_ff;
   node_type node_in;

   assign lt_out   = node_less(ins_node, node_ff);
   assign node_out = node_ff;

   always_comb begin
      node_in = node_ff;
      if (ctl.extract) begin
         node_in = right_node;
      end else if (ctl.insert) begin
         if (lt_left) begin
            node_in = left_node;
         end else if (lt_out) begin
            node_in = ins_node;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff.valid <= 1'b0;
      end else begin
         node_ff.valid <= node_in.valid;
      end
      node_ff.weight  <= node_in.weight;
      node_ff.min_sym <= node_in.min_sym;
      node_ff.id      <= node_in.id;
   end

endmodule

// ===== rtl/hccb_queue.sv =====
// ---------------------------------------------------------------------------
// hccb_queue: chain of cells forming a sorted node queue
// Cell zero always holds the smallest live node.
// ---------------------------------------------------------------------------
module hccb_queue import hccb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qctl_type ctl,
   input  node_type ins_node,
   output node_type head
);

   node_type nodes[ALPHA];
   logic     lts[ALPHA];

   genvar gi;
   generate
      for (gi = 0; gi < ALPHA; gi++) begin : g_cell
         node_type left_n;
         node_type right_n;
         logic     lt_l;
         if (gi == 0) begin : g_first
            assign left_n = '0;
            assign lt_l   = 1'b0;
         end else begin : g_mid
            assign left_n = nodes[gi-1];
            assign lt_l   = lts[gi-1];
         end
         if (gi == ALPHA - 1) begin : g_last
            assign right_n = '0;
         end else begin : g_inner
            assign right_n = nodes[gi+1];
         end
         hccb_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .ins_node   (ins_node),
            .left_node  (left_n),
            .right_node (right_n),
            .lt_left    (lt_l),
            .lt_out     (lts[gi]),
            .node_out   (nodes[gi])
         );
      end
   endgenerate

   assign head = nodes[0];

endmodule

// ===== rtl/huffman_canonical_code_builder.sv =====
// ---------------------------------------------------------------------------
// huffman_canonical_code_builder: canonical Huffman code construction
// Frequency table, merge queue built from a chain of cells, and table-driven
// canonical code assignment with code and rank lookups.
// ---------------------------------------------------------------------------
// Write goes from idle to the finish step; read by symbol passes through RS1 and read by
// rank through RR1 and RS1 first. Build walks over all 512 symbols, the tree nodes and
// the code lengths. One item in flight at a time; a new item is taken while a result
// waits. Reset is synchronous; afterward a pass clears the frequency and length tables,
// with no item taken until then.
module huffman_canonical_code_builder import hccb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hccb_req_if.sink   req_ch,
   hccb_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0]  lvl_ff, lvl_in;
   logic [CNT_W-1:0]  live_ff, live_in;
   logic [NODE_W-1:0] next_node_ff, next_node_in;
   logic              any_ff, any_in;
   logic              tree_ff, tree_in;
   node_type          a_ff, a_in, b_ff, b_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [CODE_W-1:0] cacc_ff, cacc_in;
   logic [CNT_W-1:0]  oacc_ff, oacc_in;
   logic [CNT_W-1:0]  prev_ff, prev_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic              built_ff, built_in;
   logic              freqnz_ff, freqnz_in;
   logic [SYM_W-1:0]  idx_ff, idx_in;
   sts_type           pstat_ff, pstat_in;
   logic [SYM_W-1:0]  psym_ff, psym_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [CODE_W-1:0] pcode_ff, pcode_in;
   logic              rvalid_ff, rvalid_in;
   sts_type           rstat_ff, rstat_in;
   logic [CNT_W-1:0]  rcount_ff, rcount_in;
   logic [SYM_W-1:0]  rsym_ff, rsym_in;
   logic [LEN_W-1:0]  rlen_ff, rlen_in;
   logic [CODE_W-1:0] rcode_ff, rcode_in;

   // tables
   logic [FREQ_BITS-1:0] freq_mem[ALPHA];
   logic [LEN_W-1:0]     len_mem[ALPHA];
   logic [CODE_W-1:0]    code_mem[ALPHA];
   logic [SYM_W-1:0]     sorted_mem[ALPHA];
   logic [NODE_W-1:0]    parent_mem[NODE_COUNT];
   logic [LEN_W-1:0]     depth_mem[ALPHA];
   logic [CNT_W-1:0]     hist_mem[LVL_CNT];
   ncode_type            ncode_mem[LVL_CNT];

   logic                 freq_we;
   logic [SYM_W-1:0]     freq_wa, freq_ra;
   logic [FREQ_BITS-1:0] freq_wd, freq_rd;
   logic                 len_we;
   logic [SYM_W-1:0]     len_wa, len_ra;
   logic [LEN_W-1:0]     len_wd, len_rd;
   logic                 code_we;
   logic [SYM_W-1:0]     code_wa, code_ra;
   logic [CODE_W-1:0]    code_wd, code_rd;
   logic                 sorted_we;
   logic [SYM_W-1:0]     sorted_wa, sorted_ra, sorted_wd, sorted_rd;
   logic                 parent_we;
   logic [NODE_W-1:0]    parent_wa, parent_ra, parent_wd, parent_rd;
   logic                 depth_we;
   logic [SYM_W-1:0]     depth_wa, depth_ra;
   logic [LEN_W-1:0]     depth_wd, depth_rd;
   logic                 hist_we;
   logic [LEN_W-1:0]     hist_wa, hist_ra;
   logic [CNT_W-1:0]     hist_wd, hist_rd;
   logic                 ncode_we;
   logic [LEN_W-1:0]     ncode_wa, ncode_ra;
   ncode_type            ncode_wd, ncode_rd;

   qctl_type          q_ctl;
   node_type          q_new, q_head;
   logic [LEN_W-1:0]  d_inc;
   logic [LEN_W-1:0]  leaf_len;
   logic [CODE_W-1:0] cnext;

   hccb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctl      (q_ctl),
      .ins_node (q_new),
      .head     (q_head)
   );

   always_ff @(posedge clock) begin
      if (freq_we) begin
         freq_mem[freq_wa] <= freq_wd;
      end
      freq_rd <= freq_mem[freq_ra];
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
      len_rd <= len_mem[len_ra];
      if (code_we) begin
         code_mem[code_wa] <= code_wd;
      end
      code_rd <= code_mem[code_ra];
      if (sorted_we) begin
         sorted_mem[sorted_wa] <= sorted_wd;
      end
      sorted_rd <= sorted_mem[sorted_ra];
      if (parent_we) begin
         parent_mem[parent_wa] <= parent_wd;
      end
      parent_rd <= parent_mem[parent_ra];
      if (depth_we) begin
         depth_mem[depth_wa] <= depth_wd;
      end
      depth_rd <= depth_mem[depth_ra];
      if (hist_we) begin
         hist_mem[hist_wa] <= hist_wd;
      end
      hist_rd <= hist_mem[hist_ra];
      if (ncode_we) begin
         ncode_mem[ncode_wa] <= ncode_wd;
      end
      ncode_rd <= ncode_mem[ncode_ra];
   end

   assign d_inc    = (depth_rd == LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : depth_rd + LEN_W'(1);
   assign leaf_len = (tree_ff && freqnz_ff) ? d_inc : '0;
   assign cnext    = (cacc_ff + CODE_W'(prev_ff)) << 1;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rvalid_ff;
   assign rsp_ch.status      = rstat_ff;
   assign rsp_ch.coded_count = rcount_ff;
   assign rsp_ch.out_symbol  = rsym_ff;
   assign rsp_ch.code_length = rlen_ff;
   assign rsp_ch.code_bits   = rcode_ff;

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      lvl_in       = lvl_ff;
      live_in      = live_ff;
      next_node_in = next_node_ff;
      any_in       = any_ff;
      tree_in      = tree_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      len_in       = len_ff;
      cacc_in      = cacc_ff;
      oacc_in      = oacc_ff;
      prev_in      = prev_ff;
      used_in      = used_ff;
      built_in     = built_ff;
      freqnz_in    = freqnz_ff;
      idx_in       = idx_ff;
      pstat_in     = pstat_ff;
      psym_in      = psym_ff;
      plen_in      = plen_ff;
      pcode_in     = pcode_ff;
      rvalid_in    = rvalid_ff && !rsp_ch.ready;
      rstat_in     = rstat_ff;
      rcount_in    = rcount_ff;
      rsym_in      = rsym_ff;
      rlen_in      = rlen_ff;
      rcode_in     = rcode_ff;

      freq_we   = 1'b0;
      freq_wa   = k_ff[SYM_W-1:0];
      freq_wd   = '0;
      freq_ra   = k_ff[SYM_W-1:0];
      len_we    = 1'b0;
      len_wa    = k_ff[SYM_W-1:0];
      len_wd    = '0;
      len_ra    = k_ff[SYM_W-1:0];
      code_we   = 1'b0;
      code_wa   = k_ff[SYM_W-1:0];
      code_wd   = ncode_rd.code;
      code_ra   = idx_ff;
      sorted_we = 1'b0;
      sorted_wa = ncode_rd.off[SYM_W-1:0];
      sorted_wd = k_ff[SYM_W-1:0];
      sorted_ra = idx_ff;
      parent_we = 1'b0;
      parent_wa = a_ff.id;
      parent_wd = next_node_ff;
      parent_ra = k_ff;
      depth_we  = 1'b0;
      depth_wa  = SYM_W'(k_ff - NODE_W'(ALPHA));
      depth_wd  = d_inc;
      depth_ra  = SYM_W'(parent_rd - NODE_W'(ALPHA));
      hist_we   = 1'b0;
      hist_wa   = len_ff;
      hist_wd   = hist_rd + CNT_W'(1);
      hist_ra   = lvl_ff;
      ncode_we  = 1'b0;
      ncode_wa  = len_ff;
      ncode_wd  = '{code: ncode_rd.code + CODE_W'(1), off: ncode_rd.off + CNT_W'(1)};
      ncode_ra  = len_ff;

      q_ctl = '0;
      q_new = '{valid: 1'b1,
                weight: a_ff.weight + b_ff.weight,
                min_sym: (a_ff.min_sym < b_ff.min_sym) ? a_ff.min_sym : b_ff.min_sym,
                id: next_node_ff};

      case (state_ff)
         ST_CLEAR: begin
            freq_we = 1'b1;
            len_we  = 1'b1;
            if (k_ff == NODE_W'(ALPHA - 1)) begin
               state_in = ST_IDLE;
            end else begin
               k_in = k_ff + NODE_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               idx_in   = req_ch.symbol_index;
               pstat_in = STS_OK;
               psym_in  = req_ch.symbol_index;
               plen_in  = '0;
               pcode_in = '0;
               state_in = ST_FINISH;
               case (cmd_type'(req_ch.command))
                  CMD_WRITE: begin
                     freq_we = 1'b1;
                     freq_wa = req_ch.symbol_index;
                     freq_wd = req_ch.frequency;
                  end
                  CMD_BUILD: begin
                     psym_in      = '0;
                     k_in         = '0;
                     live_in      = '0;
                     any_in       = 1'b0;
                     next_node_in = NODE_W'(ALPHA);
                     state_in     = ST_LOAD0;
                  end
                  CMD_READ_SYM: begin
                     if (!built_ff) begin
                        pstat_in = STS_NOT_BUILT;
                     end else begin
                        len_ra   = req_ch.symbol_index;
                        code_ra  = req_ch.symbol_index;
                        state_in = ST_RS1;
                     end
                  end
                  CMD_READ_RANK: begin
                     if (!built_ff) begin
                        pstat_in = STS_NOT_BUILT;
                     end else if ({1'b0, req_ch.symbol_index} >= used_ff) begin
                        pstat_in = STS_RANK;
                        psym_in  = '0;
                     end else begin
                        sorted_ra = req_ch.symbol_index;
                        state_in  = ST_RR1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RR1: begin
            len_ra   = sorted_rd;
            code_ra  = sorted_rd;
            psym_in  = sorted_rd;
            state_in = ST_RS1;
         end
         ST_RS1: begin
            plen_in  = len_rd;
            pcode_in = (len_rd != '0) ? code_rd : '0;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rvalid_ff || rsp_ch.ready) begin
               rvalid_in = 1'b1;
               rstat_in  = pstat_ff;
               rcount_in = used_ff;
               rsym_in   = psym_ff;
               rlen_in   = plen_ff;
               rcode_in  = pcode_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_LOAD0: begin
            // clear the length histogram alongside the load
            if (k_ff < NODE_W'(LVL_CNT)) begin
               hist_we = 1'b1;
               hist_wa = k_ff[LEN_W-1:0];
               hist_wd = '0;
            end
            state_in = ST_LOAD1;
         end
         ST_LOAD1: begin
            if (freq_rd != '0) begin
               q_ctl.insert = 1'b1;
               q_new = '{valid: 1'b1, weight: WEIGHT_W'(freq_rd),
                         min_sym: k_ff[SYM_W-1:0], id: k_ff};
               live_in = live_ff + CNT_W'(1);
               any_in  = 1'b1;
            end
            if (k_ff == NODE_W'(ALPHA - 1)) begin
               state_in = ST_MERGE_A;
            end else begin
               k_in     = k_ff + NODE_W'(1);
               state_in = ST_LOAD0;
            end
         end
         ST_MERGE_A: begin
            // drop the head every time, so the root also leaves the queue
            q_ctl.extract = 1'b1;
            if (live_ff >= CNT_W'(2)) begin
               a_in     = q_head;
               state_in = ST_MERGE_B;
            end else begin
               tree_in  = (next_node_ff != NODE_W'(ALPHA));
               state_in = ST_DINIT;
            end
         end
         ST_MERGE_B: begin
            q_ctl.extract = 1'b1;
            b_in      = q_head;
            parent_we = 1'b1;
            state_in  = ST_MERGE_C;
         end
         ST_MERGE_C: begin
            q_ctl.insert = 1'b1;
            parent_we    = 1'b1;
            parent_wa    = b_ff.id;
            next_node_in = next_node_ff + NODE_W'(1);
            live_in      = live_ff - CNT_W'(1);
            state_in     = ST_MERGE_A;
         end
         ST_DINIT: begin
            if (tree_ff) begin
               depth_we = 1'b1;
               depth_wa = SYM_W'(next_node_ff - NODE_W'(ALPHA + 1));
               depth_wd = '0;
               k_in     = next_node_ff - NODE_W'(2);
            end else begin
               k_in = NODE_W'(ALPHA - 1);
            end
            state_in = ST_N0;
         end
         ST_N0: begin
            state_in = ST_N1;
         end
         ST_N1: begin
            freqnz_in = (freq_rd != '0);
            state_in  = ST_N2;
         end
         ST_N2: begin
            if (k_ff >= NODE_W'(ALPHA)) begin
               depth_we = 1'b1;
            end else begin
               len_we = 1'b1;
               len_wd = leaf_len;
            end
            if (k_ff < NODE_W'(ALPHA) && leaf_len != '0) begin
               hist_ra  = leaf_len;
               len_in   = leaf_len;
               state_in = ST_N3;
            end else if (k_ff == '0) begin
               lvl_in   = LEN_W'(1);
               cacc_in  = '0;
               oacc_in  = '0;
               prev_in  = '0;
               state_in = ST_P0;
            end else begin
               k_in     = k_ff - NODE_W'(1);
               state_in = ST_N0;
            end
         end
         ST_N3: begin
            hist_we = 1'b1;
            if (k_ff == '0) begin
               lvl_in   = LEN_W'(1);
               cacc_in  = '0;
               oacc_in  = '0;
               prev_in  = '0;
               state_in = ST_P0;
            end else begin
               k_in     = k_ff - NODE_W'(1);
               state_in = ST_N0;
            end
         end
         ST_P0: begin
            state_in = ST_P1;
         end
         ST_P1: begin
            // first code and first rank of each length
            ncode_we = 1'b1;
            ncode_wa = lvl_ff;
            ncode_wd = '{code: cnext, off: oacc_ff};
            cacc_in  = cnext;
            oacc_in  = oacc_ff + hist_rd;
            prev_in  = hist_rd;
            if (lvl_ff == LEN_W'(MAX_LEN)) begin
               used_in  = oacc_ff + hist_rd;
               built_in = 1'b1;
               k_in     = '0;
               state_in = ST_A0;
            end else begin
               lvl_in   = lvl_ff + LEN_W'(1);
               state_in = ST_P0;
            end
         end
         ST_A0: begin
            state_in = ST_A1;
         end
         ST_A1: begin
            if (len_rd != '0) begin
               ncode_ra = len_rd;
               len_in   = len_rd;
               state_in = ST_A2;
            end else if (k_ff == NODE_W'(ALPHA - 1)) begin
               pstat_in = any_ff ? STS_OK : STS_EMPTY;
               state_in = ST_FINISH;
            end else begin
               k_in     = k_ff + NODE_W'(1);
               state_in = ST_A0;
            end
         end
         ST_A2: begin
            code_we   = 1'b1;
            sorted_we = 1'b1;
            ncode_we  = 1'b1;
            if (k_ff == NODE_W'(ALPHA - 1)) begin
               pstat_in = any_ff ? STS_OK : STS_EMPTY;
               state_in = ST_FINISH;
            end else begin
               k_in     = k_ff + NODE_W'(1);
               state_in = ST_A0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         k_ff      <= '0;
         rvalid_ff <= 1'b0;
         used_ff   <= '0;
         built_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         rvalid_ff <= rvalid_in;
         used_ff   <= used_in;
         built_ff  <= built_in;
      end
      lvl_ff       <= lvl_in;
      live_ff      <= live_in;
      next_node_ff <= next_node_in;
      any_ff       <= any_in;
      tree_ff      <= tree_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      len_ff       <= len_in;
      cacc_ff      <= cacc_in;
      oacc_ff      <= oacc_in;
      prev_ff      <= prev_in;
      freqnz_ff    <= freqnz_in;
      idx_ff       <= idx_in;
      pstat_ff     <= pstat_in;
      psym_ff      <= psym_in;
      plen_ff      <= plen_in;
      pcode_ff     <= pcode_in;
      rstat_ff     <= rstat_in;
      rcount_ff    <= rcount_in;
      rsym_ff      <= rsym_in;
      rlen_ff      <= rlen_in;
      rcode_ff     <= rcode_in;
   end

   // a new result word only comes out of the finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rvalid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result word raised outside finish step");

   // the merge queue is drained whenever the block waits for a command
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !q_head.valid)
      else $error("merge queue not empty while idle");

   // the coded count never exceeds the alphabet
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(ALPHA))
      else $error("coded count out of range");

endmodule

// ===== tb/sv/huffman_canonical_code_builder_test.sv =====
// ---------------------------------------------------------------------------
// huffman_canonical_code_builder_test: self-checking bench for the code builder
// Writes symbol frequencies, builds canonical Huffman codes and reads them back
// by symbol and by rank. A behavioral model predicts every result word, and
// random gaps and stalls are applied on both channels.
// ---------------------------------------------------------------------------
module huffman_canonical_code_builder_test import hccb_pkg::*; ();

   typedef struct {
      cmd_type              cmd;
      logic [SYM_W-1:0]     idx;
      logic [FREQ_BITS-1:0] freq;
      bit                   drain;   // wait for every result before offering
   } request_type;

   typedef struct {
      logic [STS_W-1:0]  status;
      logic [CNT_W-1:0]  count;
      logic [SYM_W-1:0]  sym;
      logic [LEN_W-1:0]  len;
      logic [CODE_W-1:0] code;
   } result_type;

   logic clock;
   logic reset;

   hccb_req_if req_ch();
   hccb_rsp_if rsp_ch();

   huffman_canonical_code_builder dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   request_type pending_words[$];
   result_type  expected_results[$];

   // code table model
   logic [FREQ_BITS-1:0] freq_mdl[ALPHA];
   logic [LEN_W-1:0]     len_mdl[ALPHA];
   logic [CODE_W-1:0]    code_mdl[ALPHA];
   logic [SYM_W-1:0]     rank_mdl[ALPHA];
   int                   coded_mdl;
   bit                   built_mdl;

   // tree scratch for the model
   logic [63:0]      tree_wt[NODE_COUNT];
   logic [SYM_W-1:0] tree_ms[NODE_COUNT];
   int               tree_par[NODE_COUNT];
   bit               tree_live[NODE_COUNT];

   int  errors;
   int  n_builds, n_reads, n_writes, n_results;
   int  idle_cycles;
   bit  no_idle;

   function automatic int gap_len();
      int r;
      r = $urandom_range(99, 0);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic int pick_least(int limit);
      int best;
      best = -1;
      for (int i = 0; i < limit; i++) begin
         if (tree_live[i] && (best < 0 || tree_wt[i] < tree_wt[best] ||
             (tree_wt[i] == tree_wt[best] && tree_ms[i] < tree_ms[best])))
            best = i;
      end
      if (best >= 0) tree_live[best] = 1'b0;
      return best;
   endfunction

   function automatic void build_tables();
      int live, nxt, a, b, d, node, n, prev;
      logic [CODE_W-1:0] code;
      live = 0;
      nxt  = ALPHA;
      n    = 0;
      prev = 0;
      code = '0;
      coded_mdl = 0;
      built_mdl = 1'b1;
      for (int i = 0; i < NODE_COUNT; i++) tree_live[i] = 1'b0;
      for (int s = 0; s < ALPHA; s++) begin
         len_mdl[s] = '0;
         if (freq_mdl[s] != 0) begin
            tree_wt[s]   = 64'(freq_mdl[s]);
            tree_ms[s]   = SYM_W'(s);
            tree_par[s]  = 0;
            tree_live[s] = 1'b1;
            live++;
         end
      end
      if (live < 2) return;
      while (live > 1) begin
         a = pick_least(nxt);
         b = pick_least(nxt);
         tree_wt[nxt]   = tree_wt[a] + tree_wt[b];
         tree_ms[nxt]   = (tree_ms[a] < tree_ms[b]) ? tree_ms[a] : tree_ms[b];
         tree_par[a]    = nxt;
         tree_par[b]    = nxt;
         tree_live[nxt] = 1'b1;
         nxt++;
         live--;
      end
      // walk each leaf up to the root
      for (int s = 0; s < ALPHA; s++) begin
         if (freq_mdl[s] != 0) begin
            d = 0;
            node = s;
            while (node != nxt - 1) begin
               node = tree_par[node];
               d++;
            end
            len_mdl[s] = LEN_W'((d > MAX_LEN) ? MAX_LEN : d);
         end
      end
      for (int l = 1; l <= MAX_LEN; l++) begin
         for (int s = 0; s < ALPHA; s++) begin
            if (len_mdl[s] == l) begin
               if (n == 0) prev = l;
               if (l > prev) begin
                  code = code << (l - prev);
                  prev = l;
               end
               code_mdl[s] = code;
               rank_mdl[n] = SYM_W'(s);
               n++;
               code = (code + 64'd1) & ((64'd1 << l) - 64'd1);
            end
         end
      end
      coded_mdl = n;
   endfunction

   function automatic result_type predict_result(request_type w);
      result_type r;
      bit any;
      r.status = STS_OK;
      r.sym    = '0;
      r.len    = '0;
      r.code   = '0;
      case (w.cmd)
         CMD_WRITE: begin
            freq_mdl[w.idx] = w.freq;
            r.sym = w.idx;
         end
         CMD_BUILD: begin
            build_tables();
            any = 1'b0;
            for (int s = 0; s < ALPHA; s++) any |= (freq_mdl[s] != 0);
            if (!any) r.status = STS_EMPTY;
         end
         default: begin
            if (!built_mdl) begin
               r.status = STS_NOT_BUILT;
               r.sym    = w.idx;
            end else if (w.cmd == CMD_READ_SYM) begin
               r.sym = w.idx;
               if (len_mdl[w.idx] != 0) begin
                  r.len  = len_mdl[w.idx];
                  r.code = code_mdl[w.idx];
               end
            end else if (w.idx >= coded_mdl) begin
               r.status = STS_RANK;
            end else begin
               r.sym  = rank_mdl[w.idx];
               r.len  = len_mdl[rank_mdl[w.idx]];
               r.code = code_mdl[rank_mdl[w.idx]];
            end
         end
      endcase
      r.count = CNT_W'(coded_mdl);
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // driver
   int send_gap;

   always @(posedge clock) begin
      request_type w;
      bit offer;
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.command      <= CMD_WRITE;
         req_ch.symbol_index <= '0;
         req_ch.frequency    <= '0;
         send_gap = 0;
      end else if (req_ch.valid && !req_ch.ready) begin
         // hold the word until taken
      end else begin
         if (req_ch.valid) begin
            w.cmd   = cmd_type'(req_ch.command);
            w.idx   = req_ch.symbol_index;
            w.freq  = req_ch.frequency;
            w.drain = 1'b0;
            expected_results = {expected_results, predict_result(w)};
            case (w.cmd)
               CMD_WRITE: n_writes++;
               CMD_BUILD: n_builds++;
               default:   n_reads++;
            endcase
            send_gap = gap_len();
         end
         offer = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
         end else if (pending_words.size() != 0 &&
                      !(pending_words[0].drain && expected_results.size() != 0)) begin
            w = pending_words.pop_front();
            req_ch.command      <= w.cmd;
            req_ch.symbol_index <= w.idx;
            req_ch.frequency    <= w.freq;
            offer = 1'b1;
         end
         req_ch.valid <= offer;
      end
   end

   // monitor and checker
   int  recv_gap, hold_cnt;
   bit  long_hold_done;
   always @(posedge clock) begin
      result_type e;
      bit rdy;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
         hold_cnt = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            n_results++;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result word status=%0d sym=%0d", $time,
                        rsp_ch.status, rsp_ch.out_symbol);
               errors++;
            end else begin
               e = expected_results.pop_front();
               if (rsp_ch.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status,
                           rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.coded_count !== e.count) begin
                  $display("%0t: coded_count expected %0d actual %0d", $time, e.count,
                           rsp_ch.coded_count);
                  errors++;
               end
               if (rsp_ch.out_symbol !== e.sym) begin
                  $display("%0t: out_symbol expected %0d actual %0d", $time, e.sym,
                           rsp_ch.out_symbol);
                  errors++;
               end
               if (rsp_ch.code_length !== e.len) begin
                  $display("%0t: code_length expected %0d actual %0d", $time, e.len,
                           rsp_ch.code_length);
                  errors++;
               end
               if (rsp_ch.code_bits !== e.code) begin
                  $display("%0t: code_bits expected %h actual %h", $time, e.code,
                           rsp_ch.code_bits);
                  errors++;
               end
            end
            recv_gap = gap_len();
            // stall the output long enough to back up the input
            if (n_results == 300 && !long_hold_done) begin
               hold_cnt = 400;
               long_hold_done = 1'b1;
            end
         end
         rdy = 1'b0;
         if (hold_cnt > 0) hold_cnt--;
         else if (recv_gap > 0) recv_gap--;
         else rdy = 1'b1;
         rsp_ch.ready <= rdy;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= 30000) begin
         $display("huffman_canonical_code_builder test failed");
         $finish;
      end
   end

   // stimulus
   bit used_map[ALPHA];
   int queued;

   task automatic put(cmd_type c, int idx, logic [31:0] f = 0, bit drain = 0);
      request_type w;
      w.cmd   = c;
      w.idx   = SYM_W'(idx);
      w.freq  = f;
      w.drain = drain;
      pending_words = {pending_words, w};
      if (c == CMD_WRITE) used_map[idx] = (f != 0);
      queued++;
   endtask

   function automatic logic [31:0] rand_freq(int mode);
      case (mode)
         0: return $urandom();
         1: return $urandom_range(4, 1);
         default: return $urandom_range(1000, 1);
      endcase
   endfunction

   task automatic run_phase(int k, int mode, bit drain);
      int s, nreads, r;
      for (int i = 0; i < ALPHA; i++)
         if (used_map[i]) put(CMD_WRITE, i, 0);
      for (int i = 0; i < k; i++) begin
         if (k == ALPHA) s = i;
         else s = $urandom_range(ALPHA - 1, 0);
         put(CMD_WRITE, s, rand_freq(mode));
         if ($urandom_range(9, 0) == 0) put(CMD_READ_SYM, $urandom_range(ALPHA - 1, 0));
      end
      put(CMD_BUILD, 0, 0, drain);
      nreads = (k == ALPHA) ? 40 : $urandom_range(20, 6);
      for (int i = 0; i < nreads; i++) begin
         r = $urandom_range(9, 0);
         if (r < 4) begin
            s = $urandom_range(ALPHA - 1, 0);
            for (int t = 0; t < 20 && !used_map[s]; t++) s = $urandom_range(ALPHA - 1, 0);
            put(CMD_READ_SYM, s);
         end else if (r < 5) begin
            put(CMD_READ_SYM, $urandom_range(ALPHA - 1, 0));
         end else if (r < 9) begin
            put(CMD_READ_RANK, $urandom_range((k > 1) ? k : 1, 0));
         end else begin
            put(CMD_READ_RANK, $urandom_range(ALPHA - 1, 0));
         end
      end
   endtask

   initial begin
      logic [31:0] fa, fb, ft;
      errors = 0;
      queued = 0;
      no_idle = 1'b0;
      for (int s = 0; s < ALPHA; s++) begin
         freq_mdl[s] = '0;
         len_mdl[s]  = '0;
         code_mdl[s] = '0;
         rank_mdl[s] = '0;
         used_map[s] = 1'b0;
      end
      coded_mdl = 0;
      built_mdl = 1'b0;

      // reads before any build, then an empty build
      put(CMD_READ_SYM, 511);
      put(CMD_READ_RANK, 0);
      put(CMD_BUILD, 0);
      put(CMD_READ_RANK, 0);
      // lone used symbol
      put(CMD_WRITE, 7, 32'd5);
      put(CMD_BUILD, 0);
      put(CMD_READ_SYM, 7);
      put(CMD_READ_RANK, 0);
      // two symbols at the field extremes
      put(CMD_WRITE, 0, 32'hFFFF_FFFF);
      put(CMD_WRITE, 511, 32'd1);
      put(CMD_WRITE, 7, 32'd0);
      put(CMD_BUILD, 0);
      put(CMD_READ_SYM, 0);
      put(CMD_READ_SYM, 511);
      put(CMD_READ_SYM, 7);
      put(CMD_READ_RANK, 1);
      put(CMD_READ_RANK, 2);
      put(CMD_READ_RANK, 511);
      // equal weights, order by smallest symbol
      put(CMD_WRITE, 300, 32'hFFFF_FFFF);
      put(CMD_WRITE, 100, 32'hFFFF_FFFF);
      put(CMD_BUILD, 0, 0, 1);
      put(CMD_READ_RANK, 0);
      put(CMD_READ_RANK, 3);
      // write after build leaves old codes readable
      put(CMD_WRITE, 100, 32'd2);
      put(CMD_READ_SYM, 100);

      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fibonacci weights give a deep, skewed tree
      for (int i = 0; i < ALPHA; i++)
         if (used_map[i]) put(CMD_WRITE, i, 0);
      fa = 1;
      fb = 1;
      for (int i = 0; i < 45; i++) begin
         put(CMD_WRITE, 40 + 9 * i, fa);
         ft = fa + fb;
         fa = fb;
         fb = ft;
      end
      put(CMD_BUILD, 0);
      put(CMD_READ_RANK, 0);
      put(CMD_READ_RANK, 43);
      put(CMD_READ_RANK, 44);
      put(CMD_READ_SYM, 40);
      put(CMD_READ_SYM, 40 + 9 * 44);

      while (queued < 400) begin
         while (pending_words.size() > 50) @(posedge clock);
         no_idle = ($urandom_range(4, 0) == 0);
         case ($urandom_range(9, 0))
            0:       run_phase($urandom_range(1, 0), $urandom_range(2, 0), 0);
            1:       run_phase($urandom_range(64, 25), $urandom_range(2, 0), 0);
            default: run_phase($urandom_range(16, 2), $urandom_range(2, 0),
                               $urandom_range(7, 0) == 0);
         endcase
      end
      // every symbol used
      no_idle = 1'b0;
      run_phase(ALPHA, 0, 1);

      while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d writes, %0d builds, %0d reads; %0d result words checked",
               n_writes, n_builds, n_reads, n_results);
      if (errors == 0)
         $display("huffman_canonical_code_builder test passed");
      else
         $display("huffman_canonical_code_builder test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hccb_pkg.sv
rtl/hccb_if.sv
rtl/hccb_cell.sv
rtl/hccb_queue.sv
rtl/huffman_canonical_code_builder.sv
tb/sv/huffman_canonical_code_builder_test.sv
